[sv/ffba_pkg.sv]
package ffba_pkg;

	localparam int OP_W     = 1;
	localparam int REQ_W    = 16;
	localparam int OFF_W    = 13;
	localparam int STATUS_W = 3;

	localparam int DEF_HEAP_BYTES   = 8192;
	localparam int DEF_ALIGN_BYTES  = 8;
	localparam int DEF_HEADER_BYTES = 24;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [REQ_W-1:0] request_size;
		logic [OFF_W-1:0] free_offset;
	} ffba_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    payload_offset;
	} ffba_rsp_t;

endpackage

[sv/ffba_ram.sv]
module ffba_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/ffba_seq.sv]
module ffba_seq import ffba_pkg::*; #(
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int ALIGN_BYTES  = DEF_ALIGN_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	localparam int DEPTH   = HEAP_BYTES / ALIGN_BYTES,
	localparam int IDX_W   = $clog2(DEPTH),
	localparam int SIZE_W  = $clog2(HEAP_BYTES + 1),
	localparam int ENTRY_W = SIZE_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffba_cmd_t          command,
	output logic               busy,
	output logic               done,
	output ffba_rsp_t          result,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output logic [ENTRY_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]   mem_raddr,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	localparam int ARITH_W  = (SIZE_W + 2 > 18) ? SIZE_W + 2 : 18;
	localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
	localparam int LIMIT    = HEAP_BYTES / (HEADER_BYTES + ALIGN_BYTES) + 2;
	localparam int GUARD_W  = $clog2(LIMIT + 1);

	localparam logic [ARITH_W-1:0] HDR_A   = ARITH_W'(HEADER_BYTES);
	localparam logic [ARITH_W-1:0] ALIGN_A = ARITH_W'(ALIGN_BYTES);
	localparam logic [ARITH_W-1:0] HEAP_A  = ARITH_W'(HEAP_BYTES);
	localparam logic [ARITH_W-1:0] AMASK_A = ARITH_W'(ALIGN_BYTES - 1);
	localparam logic [GUARD_W-1:0] LIMIT_G = GUARD_W'(LIMIT);
	localparam logic [SIZE_W-1:0]  INIT_SZ = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_AEVAL  = 4'd2;
	localparam logic [3:0] S_AHEAD  = 4'd3;
	localparam logic [3:0] S_FNEXT  = 4'd4;
	localparam logic [3:0] S_FFOUND = 4'd5;
	localparam logic [3:0] S_MISSUE = 4'd6;
	localparam logic [3:0] S_MEVAL  = 4'd7;
	localparam logic [3:0] S_PEVAL  = 4'd8;

	function automatic logic [IDX_W-1:0] idx_of(input logic [ARITH_W-1:0] pos);
		logic [ARITH_W-1:0] q;
		q = pos >> ALIGN_LG;
		if (q >= ARITH_W'(DEPTH)) begin
			q = ARITH_W'(DEPTH - 1);
		end
		return q[IDX_W-1:0];
	endfunction

	logic [3:0]         state_q, state_d;
	logic [ARITH_W-1:0] pos_q, pos_d;
	logic [ARITH_W-1:0] prev_q, prev_d;
	logic               have_prev_q, have_prev_d;
	logic [GUARD_W-1:0] guard_q, guard_d;
	logic [ARITH_W-1:0] sz_q, sz_d;
	logic [OFF_W-1:0]   target_q, target_d;
	logic [ARITH_W-1:0] abs_pos_q, abs_pos_d;
	logic [SIZE_W-1:0]  abs_size_q, abs_size_d;
	logic               phase_q, phase_d;
	logic               done_q, done_d;
	ffba_rsp_t          result_q, result_d;

	logic [SIZE_W-1:0]  rd_size;
	logic               rd_free;
	logic [ARITH_W-1:0] rd_size_a;
	logic [ARITH_W-1:0] nx_walk;
	logic [ARITH_W-1:0] nx_abs;
	logic [ARITH_W-1:0] merged;
	logic [ARITH_W-1:0] req_round;
	logic [ARITH_W-1:0] cmd_target;
	logic               merge_end;

	assign rd_size    = mem_rdata[ENTRY_W-1:1];
	assign rd_free    = mem_rdata[0];
	assign rd_size_a  = ARITH_W'(rd_size);
	assign nx_walk    = pos_q + HDR_A + rd_size_a;
	assign nx_abs     = abs_pos_q + HDR_A + ARITH_W'(abs_size_q);
	assign merged     = ARITH_W'(abs_size_q) + HDR_A + rd_size_a;
	assign req_round  = (ARITH_W'(command.request_size) + AMASK_A) & ~AMASK_A;
	assign cmd_target = ARITH_W'(command.free_offset);

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		prev_d      = prev_q;
		have_prev_d = have_prev_q;
		guard_d     = guard_q;
		sz_d        = sz_q;
		target_d    = target_q;
		abs_pos_d   = abs_pos_q;
		abs_size_d  = abs_size_q;
		phase_d     = phase_q;
		done_d      = 1'b0;
		result_d    = result_q;
		mem_we      = 1'b0;
		mem_waddr   = idx_of(pos_q);
		mem_wdata   = '0;
		mem_raddr   = idx_of(pos_q);
		merge_end   = 1'b0;

		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {INIT_SZ, 1'b1};
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					pos_d     = '0;
					mem_raddr = '0;
					if (command.operation == OP_ALLOC) begin
						if (command.request_size == '0) begin
							done_d   = 1'b1;
							result_d = '{status: ST_ZERO_SIZE, payload_offset: '0};
						end else begin
							sz_d    = req_round;
							guard_d = GUARD_W'(1);
							state_d = S_AEVAL;
						end
					end else begin
						target_d = command.free_offset;
						if (HDR_A == cmd_target) begin
							have_prev_d = 1'b0;
							state_d     = S_FFOUND;
						end else begin
							prev_d      = '0;
							have_prev_d = 1'b1;
							guard_d     = GUARD_W'(1);
							state_d     = S_FNEXT;
						end
					end
				end
			end
			// header at pos_q is on the read port
			S_AEVAL: begin
				if (rd_free && rd_size_a >= sz_q) begin
					mem_we = 1'b1;
					if (rd_size_a >= sz_q + HDR_A + ALIGN_A) begin
						// split: tail header first, head on the next cycle
						mem_waddr = idx_of(pos_q + HDR_A + sz_q);
						mem_wdata = {SIZE_W'(rd_size_a - sz_q - HDR_A), 1'b1};
						state_d   = S_AHEAD;
					end else begin
						mem_waddr = idx_of(pos_q);
						mem_wdata = {rd_size, 1'b0};
						done_d    = 1'b1;
						result_d  = '{status: ST_ALLOCATED,
							payload_offset: OFF_W'(pos_q + HDR_A)};
						state_d   = S_IDLE;
					end
				end else if (nx_walk < HEAP_A && guard_q < LIMIT_G) begin
					pos_d     = nx_walk;
					guard_d   = guard_q + 1'b1;
					mem_raddr = idx_of(nx_walk);
				end else begin
					done_d   = 1'b1;
					result_d = '{status: ST_NO_FIT, payload_offset: '0};
					state_d  = S_IDLE;
				end
			end
			S_AHEAD: begin
				mem_we    = 1'b1;
				mem_waddr = idx_of(pos_q);
				mem_wdata = {SIZE_W'(sz_q), 1'b0};
				done_d    = 1'b1;
				result_d  = '{status: ST_ALLOCATED, payload_offset: OFF_W'(pos_q + HDR_A)};
				state_d   = S_IDLE;
			end
			S_FNEXT: begin
				if (nx_walk < HEAP_A && guard_q < LIMIT_G) begin
					pos_d     = nx_walk;
					mem_raddr = idx_of(nx_walk);
					if (nx_walk + HDR_A == ARITH_W'(target_q)) begin
						state_d = S_FFOUND;
					end else begin
						prev_d      = nx_walk;
						have_prev_d = 1'b1;
						guard_d     = guard_q + 1'b1;
					end
				end else begin
					done_d   = 1'b1;
					result_d = '{status: ST_IGNORED, payload_offset: '0};
					state_d  = S_IDLE;
				end
			end
			S_FFOUND: begin
				if (rd_free) begin
					done_d   = 1'b1;
					result_d = '{status: ST_IGNORED, payload_offset: '0};
					state_d  = S_IDLE;
				end else begin
					mem_we     = 1'b1;
					mem_waddr  = idx_of(pos_q);
					mem_wdata  = {rd_size, 1'b1};
					abs_pos_d  = pos_q;
					abs_size_d = rd_size;
					guard_d    = '0;
					phase_d    = 1'b0;
					state_d    = S_MISSUE;
				end
			end
			S_MISSUE: begin
				if (guard_q < LIMIT_G && nx_abs < HEAP_A) begin
					guard_d   = guard_q + 1'b1;
					mem_raddr = idx_of(nx_abs);
					state_d   = S_MEVAL;
				end else begin
					merge_end = 1'b1;
				end
			end
			S_MEVAL: begin
				if (rd_free) begin
					abs_size_d = SIZE_W'(merged);
					mem_we     = 1'b1;
					mem_waddr  = idx_of(abs_pos_q);
					mem_wdata  = {SIZE_W'(merged), 1'b1};
					state_d    = S_MISSUE;
				end else begin
					merge_end = 1'b1;
				end
			end
			S_PEVAL: begin
				if (rd_free) begin
					abs_pos_d  = prev_q;
					abs_size_d = rd_size;
					guard_d    = '0;
					phase_d    = 1'b1;
					state_d    = S_MISSUE;
				end else begin
					done_d   = 1'b1;
					result_d = '{status: ST_FREED, payload_offset: '0};
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// forward merge finished: check the previous block or report
		if (merge_end) begin
			if (!phase_q && have_prev_q) begin
				mem_raddr = idx_of(prev_q);
				state_d   = S_PEVAL;
			end else begin
				done_d   = 1'b1;
				result_d = '{status: ST_FREED, payload_offset: '0};
				state_d  = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q       <= pos_d;
		prev_q      <= prev_d;
		have_prev_q <= have_prev_d;
		guard_q     <= guard_d;
		sz_q        <= sz_d;
		target_q    <= target_d;
		abs_pos_q   <= abs_pos_d;
		abs_size_q  <= abs_size_d;
		phase_q     <= phase_d;
		result_q    <= result_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[sv/first_fit_block_allocator.sv]
// First-fit heap allocator with coalescing.
// Command side: a transaction is taken at a rising edge with start high and busy
// low; command carries operation (allocate or free), request_size and free_offset.
// Result side: done pulses for exactly one cycle with result (status and
// payload_offset); the receiver cannot hold it off, so nothing stalls there.
// busy drops in the same cycle done rises, so a new command can be taken
// while the previous result is on the ports.
// Timing: the walk visits one block header per cycle, set by the single read
// port of the header RAM (registered read). Allocate inspects headers in turn
// and writes one more header when the block is split. Free walks the headers
// to reach the target block (none to walk for the first), checks its free
// mark, then each merge pass issues a read and then evaluates each header it
// looks at, and stops at the heap end; the previous block is checked last.
// A zero-size allocate answers the next cycle without raising busy. Worst case
// is about HEAP/(HEADER+ALIGN) headers, 256 with default parameters.
// Reset: busy stays high for one cycle after reset while the first header
// (one free block covering the whole heap) is written into the RAM.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int ALIGN_BYTES  = DEF_ALIGN_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ffba_cmd_t command,
	output logic      busy,
	output logic      done,
	output ffba_rsp_t result
);

	// header RAM: one entry per alignment granule, {payload size, free mark}
	localparam int DEPTH   = HEAP_BYTES / ALIGN_BYTES;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int SIZE_W  = $clog2(HEAP_BYTES + 1);
	localparam int ENTRY_W = SIZE_W + 1;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// sequencer: allocate walk, free search, forward/backward merge
	ffba_seq #(
		.HEAP_BYTES   (HEAP_BYTES),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entries other than the first are undefined until a split or merge writes them
	ffba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_hdr_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
